[rtl/phtbl_pkg.sv]
package phtbl_pkg;

  // default table geometry
  localparam int SLOTS_DEF     = 1024;
  localparam int SLOT_BITS_DEF = 10;

  // fixed field widths
  localparam int ID_W      = 32;
  localparam int IDX_OUT_W = 10;

  // request codes
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_LOOKUP  = 2'd2;
  localparam logic [1:0] REQ_CURRENT = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_BADID  = 2'd2;
  localparam logic [1:0] ST_DENIED = 2'd3;

  // one request item
  typedef struct packed {
    logic [1:0]      req_type;
    logic [ID_W-1:0] env_id;
    logic [ID_W-1:0] par_ident;
    logic            check_perm;
  } req_t;

  // one result item
  typedef struct packed {
    logic [1:0]           status;
    logic                 has_entry;
    logic [IDX_OUT_W-1:0] slot_index;
    logic [ID_W-1:0]      out_id;
    logic [ID_W-1:0]      out_parent;
  } rsp_t;

endpackage

[rtl/phtbl_ram.sv]
module phtbl_ram import phtbl_pkg::*; #(
  parameter int DEPTH  = SLOTS_DEF,
  parameter int ADDR_W = SLOT_BITS_DEF,
  parameter int DATA_W = ID_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/process_handle_table.sv]
// result: the accepting edge moves the sequencer to its execute state, and the
//   result strobe (done) and the result item are registered from that state
// busy: high for the one cycle in which the slot and freed-stack memory reads
//   are consumed and written back; no new item is accepted while busy is high
// reset: synchronous, clears counters, current slot and handshake; memories
//   keep their contents, liveness is bounded by the fresh-slot counter
module process_handle_table import phtbl_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int SLOT_BITS = SLOT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t cmd,
  output logic busy,
  output logic done,
  output rsp_t result
);

  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int GEN_W  = ID_W - SLOT_BITS - 1;
  localparam int WORD_W = 1 + 2 * ID_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic st;
  logic accept;
  req_t req_q;

  logic [CNT_W-1:0]     freed_count, freed_count_next;
  logic [CNT_W-1:0]     fresh_next, fresh_next_next;
  logic [GEN_W-1:0]     generation, generation_next;
  logic                 current_valid, current_valid_next;
  logic [SLOT_BITS-1:0] current_slot, current_slot_next;
  logic [ID_W-1:0]      cur_ident, cur_ident_next;
  logic [ID_W-1:0]      cur_parent, cur_parent_next;
  rsp_t                 rsp_next;

  // memory ports
  logic                 slot_we;
  logic [SLOT_BITS-1:0] slot_waddr;
  logic [WORD_W-1:0]    slot_wdata;
  logic [WORD_W-1:0]    slot_rdata;
  logic                 stack_we;
  logic [SLOT_BITS-1:0] stack_waddr;
  logic [SLOT_BITS-1:0] stack_rdata;

  // decoded slot word and request fields
  logic                 rd_live;
  logic [ID_W-1:0]      rd_ident;
  logic [ID_W-1:0]      rd_parent;
  logic [SLOT_BITS-1:0] ix;
  logic                 id_ok;
  logic                 from_stack;
  logic                 full;
  logic [SLOT_BITS-1:0] alloc_slot;
  logic [GEN_W-1:0]     gen_inc;
  logic [ID_W-1:0]      new_ident;

  assign accept = start && !busy;
  assign busy   = (st == S_EXEC);

  // slot memory: live mark, identifier, parent
  phtbl_ram #(
    .DEPTH  (SLOTS),
    .ADDR_W (SLOT_BITS),
    .DATA_W (WORD_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (accept),
    .raddr (cmd.env_id[SLOT_BITS-1:0]),
    .rdata (slot_rdata)
  );

  // freed-slot stack, top entry read on every accepted item
  phtbl_ram #(
    .DEPTH  (SLOTS),
    .ADDR_W (SLOT_BITS),
    .DATA_W (SLOT_BITS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (ix),
    .re    (accept),
    .raddr (SLOT_BITS'(freed_count - 1'b1)),
    .rdata (stack_rdata)
  );

  // id validation against the slot word just read
  assign rd_live   = slot_rdata[WORD_W-1];
  assign rd_ident  = slot_rdata[2*ID_W-1:ID_W];
  assign rd_parent = slot_rdata[ID_W-1:0];
  assign ix        = req_q.env_id[SLOT_BITS-1:0];
  assign id_ok     = (ID_W'(ix) < ID_W'(fresh_next)) && rd_live &&
                     (rd_ident == req_q.env_id);

  // allocation source and new identifier
  assign from_stack = (freed_count != '0);
  assign full       = !from_stack && (fresh_next == CNT_W'(SLOTS));
  assign alloc_slot = from_stack ? stack_rdata : SLOT_BITS'(fresh_next);
  assign gen_inc    = generation + 1'b1;
  assign new_ident  = {gen_inc, 1'b0, alloc_slot};

  // request execution and write-back
  always_comb begin
    freed_count_next   = freed_count;
    fresh_next_next    = fresh_next;
    generation_next    = generation;
    current_valid_next = current_valid;
    current_slot_next  = current_slot;
    cur_ident_next     = cur_ident;
    cur_parent_next    = cur_parent;
    slot_we            = 1'b0;
    slot_waddr         = alloc_slot;
    slot_wdata         = {1'b1, new_ident, req_q.par_ident};
    stack_we           = 1'b0;
    stack_waddr        = SLOT_BITS'(freed_count);
    rsp_next           = '0;
    if (st == S_EXEC) begin
      case (req_q.req_type)
        REQ_ALLOC: begin
          if (full) begin
            rsp_next.status = ST_NOFREE;
          end else begin
            if (from_stack) begin
              freed_count_next = freed_count - 1'b1;
            end else begin
              fresh_next_next = fresh_next + 1'b1;
            end
            generation_next     = gen_inc;
            slot_we             = 1'b1;
            rsp_next.status     = ST_OK;
            rsp_next.has_entry  = 1'b1;
            rsp_next.slot_index = IDX_OUT_W'(alloc_slot);
            rsp_next.out_id     = new_ident;
            rsp_next.out_parent = req_q.par_ident;
          end
        end
        REQ_FREE: begin
          if (!id_ok) begin
            rsp_next.status = ST_BADID;
          end else begin
            slot_we    = 1'b1;
            slot_waddr = ix;
            slot_wdata = {1'b0, rd_ident, rd_parent};
            if (freed_count < CNT_W'(SLOTS)) begin
              stack_we         = 1'b1;
              freed_count_next = freed_count + 1'b1;
            end
            if (current_valid && (current_slot == ix)) begin
              current_valid_next = 1'b0;
              current_slot_next  = '0;
            end
            rsp_next.status = ST_OK;
          end
        end
        REQ_LOOKUP: begin
          if (req_q.env_id == '0) begin
            rsp_next.status = ST_OK;
            if (current_valid) begin
              rsp_next.has_entry  = 1'b1;
              rsp_next.slot_index = IDX_OUT_W'(current_slot);
              rsp_next.out_id     = cur_ident;
              rsp_next.out_parent = cur_parent;
            end
          end else if (!id_ok) begin
            rsp_next.status = ST_BADID;
          end else if (req_q.check_perm && (!current_valid ||
                       ((ix != current_slot) && (rd_parent != cur_ident)))) begin
            rsp_next.status = ST_DENIED;
          end else begin
            rsp_next.status     = ST_OK;
            rsp_next.has_entry  = 1'b1;
            rsp_next.slot_index = IDX_OUT_W'(ix);
            rsp_next.out_id     = rd_ident;
            rsp_next.out_parent = rd_parent;
          end
        end
        REQ_CURRENT: begin
          if (!id_ok) begin
            rsp_next.status = ST_BADID;
          end else begin
            current_valid_next  = 1'b1;
            current_slot_next   = ix;
            cur_ident_next      = rd_ident;
            cur_parent_next     = rd_parent;
            rsp_next.status     = ST_OK;
            rsp_next.has_entry  = 1'b1;
            rsp_next.slot_index = IDX_OUT_W'(ix);
            rsp_next.out_id     = rd_ident;
            rsp_next.out_parent = rd_parent;
          end
        end
        default: begin
          rsp_next.status = ST_BADID;
        end
      endcase
    end
  end

  // sequencer and table counters
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      done          <= 1'b0;
      freed_count   <= '0;
      fresh_next    <= '0;
      generation    <= '0;
      current_valid <= 1'b0;
      current_slot  <= '0;
    end else begin
      done          <= (st == S_EXEC);
      freed_count   <= freed_count_next;
      fresh_next    <= fresh_next_next;
      generation    <= generation_next;
      current_valid <= current_valid_next;
      current_slot  <= current_slot_next;
      if (accept) begin
        st <= S_EXEC;
      end else begin
        st <= S_IDLE;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_ident  <= cur_ident_next;
    cur_parent <= cur_parent_next;
    if (accept) begin
      req_q <= cmd;
    end
    if (st == S_EXEC) begin
      result <= rsp_next;
    end
  end

endmodule

[rtl/phtbl_check.sv]
module phtbl_check import phtbl_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t result
);

  // an accepted item occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // execution takes exactly one busy cycle
  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // every execution cycle yields exactly one result
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done)
    else $error("no result after execution");

  // no result without a preceding execution cycle
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an item");

  // only a successful item returns a slot
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    (done && result.has_entry) |-> (result.status == ST_OK))
    else $error("failed item returned a slot");

endmodule

bind process_handle_table phtbl_check u_phtbl_check (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
